FILE: rtl/core/sfr_pkg.sv
// Shared types and constants for the STX/ETX frame receiver.
package sfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int OFFSET_W   = 18;
    localparam int PROD_W     = RAW_W + GAIN_W;
    localparam int FRAC_SHIFT = 12;
    localparam int SCALED_W   = 29;
    localparam int POS_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;

    localparam logic [BYTE_W-1:0] STX_BYTE = 8'h02;
    localparam logic [BYTE_W-1:0] ETX_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] SUM_SEED = 8'hFF;

    localparam logic [BYTE_W-1:0] CH_BLDC  = 8'd1;
    localparam logic [BYTE_W-1:0] CH_SERVO = 8'd2;
    localparam logic [BYTE_W-1:0] CH_LED   = 8'd3;

    // Byte positions within a frame
    localparam logic [POS_W-1:0] POS_STX  = 3'd0;
    localparam logic [POS_W-1:0] POS_CHAN = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN  = 3'd2;
    localparam logic [POS_W-1:0] POS_VHI  = 3'd3;
    localparam logic [POS_W-1:0] POS_VLO  = 3'd4;
    localparam logic [POS_W-1:0] POS_CSUM = 3'd5;
    localparam logic [POS_W-1:0] POS_ETX  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLDC_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLDC_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LED_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LED_OFFSET   = 3'd5;

    localparam logic [GAIN_W-1:0]   RST_BLDC_GAIN    = 24'd334285;
    localparam logic [OFFSET_W-1:0] RST_BLDC_OFFSET  = 18'd48960;
    localparam logic [GAIN_W-1:0]   RST_SERVO_GAIN   = 24'd2621440;
    localparam logic [OFFSET_W-1:0] RST_SERVO_OFFSET = 18'd256000;
    localparam logic [GAIN_W-1:0]   RST_LED_GAIN     = 24'd1363;
    localparam logic [OFFSET_W-1:0] RST_LED_OFFSET   = 18'd192;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_START_ERR = 2'd1,
        ST_SUM_ERR   = 2'd2,
        ST_END_ERR   = 2'd3
    } t_frame_status;

endpackage

FILE: rtl/core/stx_etx_frame_receiver.sv
// STX/ETX frame receiver: byte framing, checksum check and per-channel scaling.
//
// Usage:
//   Bytes arrive on the s_axis stream, one byte per transfer in tdata[7:0].
//   Every seven bytes form one frame (STX, channel, length, value high,
//   value low, checksum, ETX); there is no resync on the start byte.
//   The seventh byte produces one result transfer on m_axis; the first six
//   produce nothing. Result status and scaled-valid flag ride in tuser, the
//   channel, raw value and scaled drive value in tdata.
//   Output: the result is in the output register in the cycle after the
//   seventh byte's transfer. Throughput: one byte per cycle while the closing
//   byte is not stalled; the scaling multiplier (16x24) sits between the
//   frame registers and the output register, so there is no other limit.
//   Stall: bytes one to six are always taken. The seventh byte is taken
//   only when the output register is empty or drains in the same cycle,
//   so a stalled downstream holds back just the closing byte.
//   Config: gain/offset registers on the cfg channel, always ready; write
//   only while no frame result is pending.
//   Reset (synchronous, active low) restores the default gains and offsets,
//   starts a new frame and empties the output register.
module stx_etx_frame_receiver
    import sfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // Frame result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] channel_number,
                                                   // [23:8] raw_value,
                                                   // [52:24] scaled_value, [55:53] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [1:0] frame_status, [2] scaled_valid
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Config registers
    logic [GAIN_W-1:0]   r_bldc_gain, r_servo_gain, r_led_gain;
    logic [OFFSET_W-1:0] r_bldc_offset, r_servo_offset, r_led_offset;

    // Frame state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_start_ok, n_start_ok;
    logic              r_sum_ok, n_sum_ok;
    logic [BYTE_W-1:0] r_chan, n_chan;
    logic [BYTE_W-1:0] r_val_hi, n_val_hi;
    logic [BYTE_W-1:0] r_val_lo, n_val_lo;

    // Output register
    logic                r_out_valid;
    t_frame_status       r_out_status;
    logic [BYTE_W-1:0]   r_out_chan;
    logic [RAW_W-1:0]    r_out_raw;
    logic [SCALED_W-1:0] r_out_scaled;
    logic                r_out_svalid;

    logic                in_xfer, out_xfer, frame_end;
    logic [BYTE_W-1:0]   rx_byte;
    logic [RAW_W-1:0]    raw;
    t_frame_status       status;
    logic                svalid;
    logic [GAIN_W-1:0]   sel_gain;
    logic [OFFSET_W-1:0] sel_offset;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;

    assign rx_byte   = s_axis_tdata[BYTE_W-1:0];
    assign out_xfer  = r_out_valid & m_axis_tready;
    // Only the closing byte needs room in the output register
    assign s_axis_tready = (r_pos != POS_ETX) | ~r_out_valid | m_axis_tready;
    assign in_xfer   = s_axis_tvalid & s_axis_tready;
    assign frame_end = in_xfer & (r_pos == POS_ETX);
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bldc_gain    <= RST_BLDC_GAIN;
            r_bldc_offset  <= RST_BLDC_OFFSET;
            r_servo_gain   <= RST_SERVO_GAIN;
            r_servo_offset <= RST_SERVO_OFFSET;
            r_led_gain     <= RST_LED_GAIN;
            r_led_offset   <= RST_LED_OFFSET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLDC_GAIN:    r_bldc_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_BLDC_OFFSET:  r_bldc_offset  <= i_cfg_data[OFFSET_W-1:0];
                REG_SERVO_GAIN:   r_servo_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_SERVO_OFFSET: r_servo_offset <= i_cfg_data[OFFSET_W-1:0];
                REG_LED_GAIN:     r_led_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_LED_OFFSET:   r_led_offset   <= i_cfg_data[OFFSET_W-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------- frame tracking ----------------
    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_start_ok = r_start_ok;
        n_sum_ok   = r_sum_ok;
        n_chan     = r_chan;
        n_val_hi   = r_val_hi;
        n_val_lo   = r_val_lo;
        if (in_xfer) begin
            case (r_pos)
                POS_CHAN: begin
                    n_chan = rx_byte;
                    n_sum  = r_sum + rx_byte;
                    n_pos  = POS_LEN;
                end
                POS_LEN: begin
                    n_sum = r_sum + rx_byte;
                    n_pos = POS_VHI;
                end
                POS_VHI: begin
                    n_val_hi = rx_byte;
                    n_sum    = r_sum + rx_byte;
                    n_pos    = POS_VLO;
                end
                POS_VLO: begin
                    n_val_lo = rx_byte;
                    n_sum    = r_sum + rx_byte;
                    n_pos    = POS_CSUM;
                end
                POS_CSUM: begin
                    n_sum_ok = (rx_byte == ~r_sum);
                    n_pos    = POS_ETX;
                end
                POS_ETX: begin
                    n_sum = SUM_SEED;
                    n_pos = POS_STX;
                end
                default: begin
                    // start byte; the unused position code behaves the same
                    n_start_ok = (rx_byte == STX_BYTE);
                    n_sum      = SUM_SEED;
                    n_pos      = POS_CHAN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_STX;
            r_sum      <= SUM_SEED;
            r_start_ok <= 1'b0;
            r_sum_ok   <= 1'b0;
            r_chan     <= '0;
            r_val_hi   <= '0;
            r_val_lo   <= '0;
        end else begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_start_ok <= n_start_ok;
            r_sum_ok   <= n_sum_ok;
            r_chan     <= n_chan;
            r_val_hi   <= n_val_hi;
            r_val_lo   <= n_val_lo;
        end
    end

    // ---------------- result of the closing byte ----------------
    assign raw = {r_val_hi, r_val_lo};

    always_comb begin
        if (!r_start_ok) begin
            status = ST_START_ERR;
        end else if (!r_sum_ok) begin
            status = ST_SUM_ERR;
        end else if (rx_byte != ETX_BYTE) begin
            status = ST_END_ERR;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        case (r_chan)
            CH_SERVO: begin
                sel_gain   = r_servo_gain;
                sel_offset = r_servo_offset;
            end
            CH_LED: begin
                sel_gain   = r_led_gain;
                sel_offset = r_led_offset;
            end
            default: begin
                sel_gain   = r_bldc_gain;
                sel_offset = r_bldc_offset;
            end
        endcase
    end

    assign svalid = (status == ST_OK) && (r_chan inside {CH_BLDC, CH_SERVO, CH_LED});
    // Q4.20 gain times 16-bit raw, drop 12 bits to get Q.8, then remove offset
    assign prod   = PROD_W'(raw) * PROD_W'(sel_gain);
    assign scaled = svalid
                  ? (SCALED_W'(prod[PROD_W-1:FRAC_SHIFT]) - SCALED_W'(sel_offset))
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (frame_end) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_end) begin
            r_out_status <= status;
            r_out_chan   <= r_chan;
            r_out_raw    <= raw;
            r_out_scaled <= scaled;
            r_out_svalid <= svalid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_scaled, r_out_raw, r_out_chan};
    assign m_axis_tuser  = {r_out_svalid, r_out_status};

`ifndef SYNTHESIS
    // closing byte always lands a result in the output register
    a_frame_end_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> r_out_valid)
        else $error("closing byte did not load a result");

    // a scaled value is only flagged on a good frame
    a_svalid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_svalid) |-> (r_out_status == ST_OK))
        else $error("scaled value flagged on an error frame");

    // a scaled value is only flagged for a drive channel
    a_svalid_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_svalid) |->
            (r_out_chan == CH_BLDC || r_out_chan == CH_SERVO || r_out_chan == CH_LED))
        else $error("scaled value flagged on a non-drive channel");

    // a pending, stalled result blocks only the closing byte
    a_stall_blocks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_pos == POS_ETX) |-> !s_axis_tready)
        else $error("closing byte taken while result register full");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the STX/ETX frame receiver: framing, checksum and scaling.
`timescale 1ns / 1ps

module tb_top
    import sfr_pkg::*;
();

    // Watchdog: cycles with no transfer on any channel before the run is abandoned.
    // The longest correct quiet stretch is the receiver hold of HOLD_CYCLES plus idle runs.
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 80;

    // One frame result as it should leave the block
    typedef struct packed {
        t_frame_status      status;
        logic [BYTE_W-1:0]  channel;
        logic [RAW_W-1:0]   raw;
        logic [SCALED_W-1:0] scaled;
        logic               valid;
    } t_frame_result;

    // Scoreboard: own copy of the frame state and the gain/offset registers, plus
    // the queue of frame results still owed by the block.
    class frame_scoreboard;
        logic [GAIN_W-1:0]   gain [3];
        logic [OFFSET_W-1:0] offs [3];
        logic [POS_W-1:0]    pos;
        logic [BYTE_W-1:0]   sum;
        logic [BYTE_W-1:0]   chan;
        logic [BYTE_W-1:0]   vhi;
        logic [BYTE_W-1:0]   vlo;
        bit                  start_ok;
        bit                  sum_ok;
        t_frame_result       owed_q [$];
        int                  errors;
        int                  checked;

        function new();
            gain[0] = RST_BLDC_GAIN;
            offs[0] = RST_BLDC_OFFSET;
            gain[1] = RST_SERVO_GAIN;
            offs[1] = RST_SERVO_OFFSET;
            gain[2] = RST_LED_GAIN;
            offs[2] = RST_LED_OFFSET;
            pos      = POS_STX;
            sum      = SUM_SEED;
            chan     = '0;
            vhi      = '0;
            vlo      = '0;
            start_ok = 1'b0;
            sum_ok   = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // ((raw * gain) >> 12) - offset, wrapped to the 29-bit result
        function logic [SCALED_W-1:0] drive_value(logic [RAW_W-1:0] raw,
                                                  logic [GAIN_W-1:0] g,
                                                  logic [OFFSET_W-1:0] o);
            logic [PROD_W-1:0] prod;
            prod = {{GAIN_W{1'b0}}, raw} * {{RAW_W{1'b0}}, g};
            return {1'b0, prod[PROD_W-1:FRAC_SHIFT]} - {{(SCALED_W-OFFSET_W){1'b0}}, o};
        endfunction

        task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BLDC_GAIN:    gain[0] = data;
                REG_BLDC_OFFSET:  offs[0] = data[OFFSET_W-1:0];
                REG_SERVO_GAIN:   gain[1] = data;
                REG_SERVO_OFFSET: offs[1] = data[OFFSET_W-1:0];
                REG_LED_GAIN:     gain[2] = data;
                REG_LED_OFFSET:   offs[2] = data[OFFSET_W-1:0];
                default: ;        // out of range: dropped
            endcase
        endtask

        task note_byte(logic [BYTE_W-1:0] b);
            t_frame_result res;
            case (pos)
                POS_CHAN: begin
                    chan = b;
                    sum  = sum + b;
                    pos  = POS_LEN;
                end
                POS_LEN: begin
                    sum = sum + b;
                    pos = POS_VHI;
                end
                POS_VHI: begin
                    vhi = b;
                    sum = sum + b;
                    pos = POS_VLO;
                end
                POS_VLO: begin
                    vlo = b;
                    sum = sum + b;
                    pos = POS_CSUM;
                end
                POS_CSUM: begin
                    sum_ok = (b == ~sum);
                    pos    = POS_ETX;
                end
                POS_ETX: begin
                    res.channel = chan;
                    res.raw     = {vhi, vlo};
                    res.scaled  = '0;
                    res.valid   = 1'b0;
                    if (!start_ok)
                        res.status = ST_START_ERR;
                    else if (!sum_ok)
                        res.status = ST_SUM_ERR;
                    else if (b != ETX_BYTE)
                        res.status = ST_END_ERR;
                    else
                        res.status = ST_OK;
                    if (res.status == ST_OK) begin
                        case (chan)
                            CH_BLDC: begin
                                res.scaled = drive_value(res.raw, gain[0], offs[0]);
                                res.valid  = 1'b1;
                            end
                            CH_SERVO: begin
                                res.scaled = drive_value(res.raw, gain[1], offs[1]);
                                res.valid  = 1'b1;
                            end
                            CH_LED: begin
                                res.scaled = drive_value(res.raw, gain[2], offs[2]);
                                res.valid  = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    owed_q.push_back(res);
                    pos = POS_STX;
                    sum = SUM_SEED;
                end
                default: begin    // start byte; the unused position acts the same
                    start_ok = (b == STX_BYTE);
                    sum      = SUM_SEED;
                    pos      = POS_CHAN;
                end
            endcase
        endtask

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h",
                         checked, what, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
            t_frame_result want;
            if (owed_q.size() == 0) begin
                report_mismatch("unexpected result, tdata low word", tdata[31:0], '0);
                return;
            end
            want = owed_q.pop_front();
            if (tuser[1:0] !== want.status)
                report_mismatch("frame_status", 32'(tuser[1:0]), 32'(want.status));
            if (tuser[2] !== want.valid)
                report_mismatch("scaled_valid", 32'(tuser[2]), 32'(want.valid));
            if (tdata[7:0] !== want.channel)
                report_mismatch("channel_number", 32'(tdata[7:0]), 32'(want.channel));
            if (tdata[23:8] !== want.raw)
                report_mismatch("raw_value", 32'(tdata[23:8]), 32'(want.raw));
            if (tdata[52:24] !== want.scaled)
                report_mismatch("scaled_value", 32'(tdata[52:24]), 32'(want.scaled));
            if (tdata[55:53] !== 3'b000)
                report_mismatch("tdata padding", 32'(tdata[55:53]), '0);
            checked++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    frame_scoreboard sb;

    bit tx_idle_en = 1'b1;      // sender inserts random gaps
    bit rx_idle_en = 1'b1;      // receiver drops tready at random
    int hold_req   = 0;         // main flow asks the receiver for a long hold-off
    int hold_left  = 0;
    int quiet      = 0;

    stx_etx_frame_receiver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Monitors: every transfer is seen at the edge where it happens, with the
    // values that were stable before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Result side: random tready, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_idle_en && $urandom_range(0, 99) < 26);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("stx_etx_frame_receiver verification failed");
                $finish;
            end
        end
    end

    // One byte transfer. tvalid stays high from one byte to the next unless
    // a gap is drawn, so it is never lowered and raised in the same step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (tx_idle_en && $urandom_range(0, 99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Seven-byte frame; the checksum is built correct and then broken on request
    task automatic send_frame(input logic [BYTE_W-1:0] stx, chan, len, hi, lo,
                              input bit bad_sum, input logic [BYTE_W-1:0] etx);
        logic [BYTE_W-1:0] csum;
        csum = ~(SUM_SEED + chan + len + hi + lo);
        if (bad_sum)
            csum = csum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(stx);
        send_byte(chan);
        send_byte(len);
        send_byte(hi);
        send_byte(lo);
        send_byte(csum);
        send_byte(etx);
    endtask

    // Mostly well-formed frames on the scaled channels with random content;
    // the rest are other channels, broken frames and whole frames of noise.
    task automatic random_frame();
        logic [BYTE_W-1:0] chan;
        logic [RAW_W-1:0]  raw;
        logic [BYTE_W-1:0] stx;
        logic [BYTE_W-1:0] etx;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            repeat (7) send_byte(8'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                case ($urandom_range(0, 2))
                    0:       chan = CH_BLDC;
                    1:       chan = CH_SERVO;
                    default: chan = CH_LED;
                endcase
            end else begin
                chan = 8'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 10)
                raw = '0;
            else if (r < 20)
                raw = '1;
            else
                raw = 16'($urandom);
            stx = ($urandom_range(0, 99) < 8) ? 8'($urandom) : STX_BYTE;
            etx = ($urandom_range(0, 99) < 8) ? 8'($urandom) : ETX_BYTE;
            send_frame(stx, chan, 8'($urandom), raw[15:8], raw[7:0],
                       $urandom_range(0, 99) < 8, etx);
        end
    endtask

    task automatic random_frames(input int count);
        repeat (count) random_frame();
    endtask

    // Sender stops offering until every owed result has been taken; the first
    // edge lets the monitor note the last byte before the count is read.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Full register update between phases: block drained, output register empty.
    // Out-of-range indexes are hit too; they must change nothing.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] bg, bo, sg, so, lg, lo);
        wait_drained();
        repeat (4) @(posedge i_clk);
        cfg_write(REG_BLDC_GAIN, bg);
        cfg_write(REG_BLDC_OFFSET, bo);
        cfg_write(REG_SERVO_GAIN, sg);
        cfg_write(REG_SERVO_OFFSET, so);
        cfg_write(REG_LED_GAIN, lg);
        cfg_write(REG_LED_OFFSET, lo);
        cfg_write(REG_LED_OFFSET + 3'd1, 24'($urandom));
        cfg_write(REG_LED_OFFSET + 3'd2, 24'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on reset register values: good BLDC frame with all-ones
        // bytes, bad start byte, bad checksum, bad end byte.
        send_frame(STX_BYTE, CH_BLDC, 8'hFF, 8'hFF, 8'hFF, 1'b0, ETX_BYTE);
        send_frame(8'h00, CH_LED, 8'h00, 8'h00, 8'h00, 1'b0, ETX_BYTE);
        send_frame(STX_BYTE, CH_SERVO, 8'h07, 8'h80, 8'h01, 1'b1, ETX_BYTE);
        send_frame(STX_BYTE, 8'hFF, 8'h00, 8'h12, 8'h34, 1'b0, 8'hFF);
        random_frames(40);

        // Zero gains and offsets
        reconfigure('0, '0, '0, '0, '0, '0);
        random_frames(30);

        // All-ones writes: offsets masked to 18 bits. Mid-phase the receiver
        // holds off long enough that the closing byte backs up, and later the
        // sender pauses until everything owed has come out.
        reconfigure('1, '1, '1, '1, '1, '1);
        random_frames(10);
        hold_req = HOLD_CYCLES;
        random_frames(15);
        wait_drained();
        random_frames(15);

        // Largest products, no offset, and a stretch at full rate on both sides
        reconfigure('1, '0, '1, '0, '1, '0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_frames(40);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // No gain, largest offset: most negative drive values
        reconfigure('0, '1, '0, '1, '0, '1);
        random_frames(30);

        repeat (3) begin
            reconfigure(24'($urandom), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 24'($urandom));
            random_frames(35);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("stx_etx_frame_receiver verification clean");
        else
            $display("stx_etx_frame_receiver verification failed");
        $finish;
    end

endmodule
